// File: rtl/core/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared constants and the built-in primality table of the Goldbach pair
// enumerator.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int MAX_VALUE   = 511;
    localparam int MAX_RESULTS = 64;

    localparam int NUM_W  = 9;
    localparam int SP_W   = 8;
    localparam int ADDR_W = $clog2(MAX_VALUE + 1);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    // sieve over the whole table, evaluated at elaboration only
    function automatic logic [MAX_VALUE:0] build_prime_mask();
        logic [MAX_VALUE:0] mask;
        int i;
        int m;
        mask = '0;
        for (i = 2; i <= MAX_VALUE; i++)
        begin
            mask[i] = 1'b1;
        end
        for (i = 2; i * i <= MAX_VALUE; i++)
        begin
            if (mask[i])
            begin
                for (m = i * i; m <= MAX_VALUE; m += i)
                begin
                    mask[m] = 1'b0;
                end
            end
        end
        return mask;
    endfunction

    localparam logic [MAX_VALUE:0] PRIME_MASK = build_prime_mask();

endpackage

// File: rtl/core/gbp_prime_rom.sv
// ----------------------------------------------------------------------------
// gbp_prime_rom
// Dual-port primality table with registered read data.
// ----------------------------------------------------------------------------
module gbp_prime_rom
(
    input  logic                       clk,
    input  logic [gbp_pkg::ADDR_W-1:0] addr_a,
    input  logic [gbp_pkg::ADDR_W-1:0] addr_b,
    output logic                       flag_a,
    output logic                       flag_b
);

    always_ff @(posedge clk)
    begin
        flag_a <= gbp_pkg::PRIME_MASK[addr_a];
        flag_b <= gbp_pkg::PRIME_MASK[addr_b];
    end

endmodule

// File: rtl/core/goldbach_pair_enumerator.sv
// ----------------------------------------------------------------------------
// goldbach_pair_enumerator
// Lists the prime pairs p + q = number with p <= number/2, in rising order, up to MAX_RESULTS (64) pairs.
// ----------------------------------------------------------------------------
// usage:
//   a request is taken when start is high and busy is low; number is
//   sampled at that edge. busy stays high until the final result is out.
//   results appear on small_prime, large_prime, none_found and last for
//   exactly one cycle each, marked by valid; the receiver cannot stall.
//   the final result of a request carries last. a number with no pair
//   gives one result with none_found set and both prime fields zero.
// timing:
//   candidates p = 2 .. number/2 are walked one per cycle through the
//   dual-port prime table, whose read data is registered. the final
//   result comes out on the edge that drops busy, so a new request can
//   follow the next cycle. each pair is held back one find so that
//   last can be set on the final one.
// reset:
//   rst_n clears the control state; the table is constant and needs no
//   load, so the block takes a request right after reset.
// ----------------------------------------------------------------------------
module goldbach_pair_enumerator
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gbp_pkg::NUM_W-1:0] number,
    output logic                      busy,
    output logic                      valid,
    output logic [gbp_pkg::SP_W-1:0]  small_prime,
    output logic [gbp_pkg::NUM_W-1:0] large_prime,
    output logic                      none_found,
    output logic                      last
);

    typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

    state_t                      state_reg, state_next;
    logic [gbp_pkg::NUM_W-1:0]   n_reg, n_next;
    logic [gbp_pkg::SP_W-1:0]    limit_reg, limit_next;
    logic [gbp_pkg::NUM_W-1:0]   p_reg, p_next;
    logic                        chk_v_reg, chk_v_next;
    logic [gbp_pkg::SP_W-1:0]    chk_p_reg, chk_p_next;
    logic                        pend_v_reg, pend_v_next;
    logic [gbp_pkg::SP_W-1:0]    pend_p_reg, pend_p_next;
    logic [gbp_pkg::CNT_W-1:0]   count_reg, count_next;

    logic                        valid_reg, valid_next;
    logic [gbp_pkg::SP_W-1:0]    sp_reg, sp_next;
    logic [gbp_pkg::NUM_W-1:0]   lp_reg, lp_next;
    logic                        none_reg, none_next;
    logic                        last_reg, last_next;

    logic                        issue;
    logic                        found;
    logic                        finish;
    logic                        flag_a;
    logic                        flag_b;
    logic [gbp_pkg::NUM_W-1:0]   addr_b;
    logic [gbp_pkg::NUM_W-1:0]   pend_large;

    gbp_prime_rom u_rom
    (
        .clk    (clk),
        .addr_a (p_reg),
        .addr_b (addr_b),
        .flag_a (flag_a),
        .flag_b (flag_b)
    );

    assign addr_b     = n_reg - p_reg;
    assign pend_large = n_reg - {1'b0, pend_p_reg};

    assign issue  = (state_reg == ST_SCAN) && (p_reg <= {1'b0, limit_reg})
                    && (count_reg < gbp_pkg::CNT_W'(gbp_pkg::MAX_RESULTS));
    // once the pair budget is used up, a candidate still in flight is dropped
    assign found  = chk_v_reg && flag_a && flag_b
                    && (count_reg < gbp_pkg::CNT_W'(gbp_pkg::MAX_RESULTS));
    assign finish = (state_reg == ST_SCAN) && !issue && !chk_v_reg;

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        limit_next  = limit_reg;
        p_next      = p_reg;
        chk_v_next  = issue;
        chk_p_next  = p_reg[gbp_pkg::SP_W-1:0];
        pend_v_next = pend_v_reg;
        pend_p_next = pend_p_reg;
        count_next  = count_reg;
        valid_next  = 1'b0;
        sp_next     = sp_reg;
        lp_next     = lp_reg;
        none_next   = none_reg;
        last_next   = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_SCAN;
                    n_next      = number;
                    // out-of-range numbers scan nothing and report none
                    if (number > gbp_pkg::NUM_W'(gbp_pkg::MAX_VALUE))
                    begin
                        limit_next = '0;
                    end
                    else
                    begin
                        limit_next = number[gbp_pkg::NUM_W-1:1];
                    end
                    p_next      = gbp_pkg::NUM_W'(2);
                    pend_v_next = 1'b0;
                    count_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    p_next = p_reg + 1'b1;
                end
                if (found)
                begin
                    // release the held pair, hold the new one
                    if (pend_v_reg)
                    begin
                        valid_next = 1'b1;
                        sp_next    = pend_p_reg;
                        lp_next    = pend_large;
                        none_next  = 1'b0;
                        last_next  = 1'b0;
                    end
                    pend_v_next = 1'b1;
                    pend_p_next = chk_p_reg;
                    count_next  = count_reg + 1'b1;
                end
                if (finish)
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    if (pend_v_reg)
                    begin
                        sp_next   = pend_p_reg;
                        lp_next   = pend_large;
                        none_next = 1'b0;
                    end
                    else
                    begin
                        sp_next   = '0;
                        lp_next   = '0;
                        none_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            limit_reg  <= '0;
            p_reg      <= '0;
            chk_v_reg  <= 1'b0;
            chk_p_reg  <= '0;
            pend_v_reg <= 1'b0;
            pend_p_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
            sp_reg     <= '0;
            lp_reg     <= '0;
            none_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            limit_reg  <= limit_next;
            p_reg      <= p_next;
            chk_v_reg  <= chk_v_next;
            chk_p_reg  <= chk_p_next;
            pend_v_reg <= pend_v_next;
            pend_p_reg <= pend_p_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            sp_reg     <= sp_next;
            lp_reg     <= lp_next;
            none_reg   <= none_next;
            last_reg   <= last_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = valid_reg;
    assign small_prime = sp_reg;
    assign large_prime = lp_reg;
    assign none_found  = none_reg;
    assign last        = last_reg;

endmodule

// File: rtl/core/gbp_checker.sv
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks of the Goldbach pair enumerator, bound to the top level.
// ----------------------------------------------------------------------------
module gbp_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      valid,
    input  logic [gbp_pkg::SP_W-1:0]  small_prime,
    input  logic [gbp_pkg::NUM_W-1:0] large_prime,
    input  logic                      none_found,
    input  logic                      last
);

    // a none result is always the only and final one, with zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && none_found |-> last && small_prime == '0 && large_prime == '0)
        else $error("none result malformed");

    // a pair has its smaller prime first
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !none_found |-> {1'b0, small_prime} <= large_prime)
        else $error("pair out of order");

    // more results follow a non-final one, so the block must still be busy
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("non-final result while idle");

    // a taken request keeps the block busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request not taken");

    // busy drops only together with a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && last)
        else $error("busy dropped without final result");

endmodule

bind goldbach_pair_enumerator gbp_checker u_gbp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .valid       (valid),
    .small_prime (small_prime),
    .large_prime (large_prime),
    .none_found  (none_found),
    .last        (last)
);

// File: verif/goldbach_pair_enumerator_tb.sv
// ----------------------------------------------------------------------------
// goldbach_pair_enumerator_tb
// Drives numbers into the Goldbach pair enumerator and checks each emitted
// prime pair, its order, the last flag and the none-found result against a
// behavioral prediction built on trial-division primality.
// ----------------------------------------------------------------------------
module goldbach_pair_enumerator_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_PER_PHASE = 56;

    typedef struct packed
    {
        logic [gbp_pkg::SP_W-1:0]  small_prime;
        logic [gbp_pkg::NUM_W-1:0] large_prime;
        logic                      none_found;
        logic                      last;
    } pair_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [gbp_pkg::NUM_W-1:0] number = '0;
    logic                      busy;
    logic                      valid;
    logic [gbp_pkg::SP_W-1:0]  small_prime;
    logic [gbp_pkg::NUM_W-1:0] large_prime;
    logic                      none_found;
    logic                      last;

    logic [gbp_pkg::NUM_W-1:0] request_q[$];
    pair_t                     pair_q[$];
    int                        idle_pct = 0;
    int                        error_count = 0;
    int                        quiet_cycles = 0;

    goldbach_pair_enumerator dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .number      (number),
        .busy        (busy),
        .valid       (valid),
        .small_prime (small_prime),
        .large_prime (large_prime),
        .none_found  (none_found),
        .last        (last)
    );

    always #1 clk = ~clk;

    function automatic bit is_prime(int v);
        int d;
        if (v < 2)
        begin
            return 1'b0;
        end
        for (d = 2; d * d <= v; d++)
        begin
            if (v % d == 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // queue the prime pairs of n, at most MAX_RESULTS, in rising order of the small prime
    function automatic void predict_pairs(logic [gbp_pkg::NUM_W-1:0] n);
        int    p;
        int    found;
        pair_t pr;
        found = 0;
        if (n <= gbp_pkg::MAX_VALUE)
        begin
            for (p = 2; p <= n / 2 && found < gbp_pkg::MAX_RESULTS; p++)
            begin
                if (is_prime(p) && is_prime(n - p))
                begin
                    pr.small_prime = p[gbp_pkg::SP_W-1:0];
                    pr.large_prime = gbp_pkg::NUM_W'(n - p);
                    pr.none_found  = 1'b0;
                    pr.last        = 1'b0;
                    pair_q.push_back(pr);
                    found++;
                end
            end
        end
        if (found == 0)
        begin
            pr = '0;
            pr.none_found = 1'b1;
            pr.last       = 1'b1;
            pair_q.push_back(pr);
        end
        else
        begin
            pair_q[pair_q.size() - 1].last = 1'b1;
        end
    endfunction

    // driver: a request holds until taken, then the next one may follow at once
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_pairs(number);
                if (request_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    number <= request_q.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
            else if (!start && request_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                start  <= 1'b1;
                number <= request_q.pop_front();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pair_t seen;
        pair_t want;
        if (rst_n && valid)
        begin
            seen = {small_prime, large_prime, none_found, last};
            if (pair_q.size() == 0)
            begin
                $display("%0t: unexpected result sp=%0d lp=%0d none=%0b last=%0b",
                         $time, small_prime, large_prime, none_found, last);
                error_count++;
            end
            else
            begin
                want = pair_q.pop_front();
                if (seen !== want)
                begin
                    $display("%0t: expected %0d/%0d/%0b/%0b actual %0d/%0d/%0b/%0b",
                             $time, want.small_prime, want.large_prime, want.none_found,
                             want.last, seen.small_prime, seen.large_prime,
                             seen.none_found, seen.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with neither a request taken nor a result out
    always @(posedge clk)
    begin
        if ((start && !busy) || valid)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [gbp_pkg::NUM_W-1:0] random_number();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            return gbp_pkg::NUM_W'($urandom_range(gbp_pkg::MAX_VALUE / 2) * 2);
        end
        else if (pick < 80)
        begin
            return gbp_pkg::NUM_W'($urandom_range(gbp_pkg::MAX_VALUE / 2) * 2 + 1);
        end
        else
        begin
            return gbp_pkg::NUM_W'($urandom_range(20));
        end
    endfunction

    task automatic wait_drained();
        while (request_q.size() != 0 || start || busy || pair_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int phase;
        int i;
        int idle_by_phase[4];
        idle_by_phase = '{0, 65, 0, 29};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest values, 4 = 2 + 2, odd numbers with and without a pair,
        // alternating bit patterns and the top of the range
        request_q = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 13, 27, 12, 100,
                      170, 341, 254, 255, 256, 498, 500, 509, 510, 511};
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_by_phase[phase];
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                request_q.push_back(random_number());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
